/* src/ssm_pkg.sv */
// sorted set merge package: item codes and controller state type
// no dependencies; imported by the top level
package ssm_pkg;

    typedef enum logic [1:0] {
        MODE_LOAD_A = 2'd0,
        MODE_LOAD_B = 2'd1,
        MODE_RUN    = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        OP_UNION     = 2'd0,
        OP_INTERSECT = 2'd1,
        OP_DIFF      = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MERGE,
        ST_FINISH
    } t_state;

    localparam int unsigned DATA_W = 32;

endpackage

/* src/ssm_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies; used for both list stores of the merge block
module ssm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/sorted_set_merge_top.sv */
// channel | direction | handshake            | payload
// in      | input     | i_valid / o_stall    | i_mode, i_value, i_operation
// out     | output    | o_valid / i_stall    | o_result_value, o_is_last, o_is_empty
//
// a load word is written as it is taken; the list heads are read at the edge that takes a run,
// then the run stalls the input for the comparison steps in ST_MERGE (at most
// count_a + count_b), the check that sees the walk end and the closing word in ST_FINISH
// the step rate is set by the two list rams, each read once per cycle
// a result is held back one step so the final word can carry is_last
// a step that must push a word waits while the output register is stalled
// reset (synchronous, active low) clears the counts, the controller and the output
module sorted_set_merge_top #(
    parameter int LIST_DEPTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [1:0]                   i_mode,
    input  logic signed [ssm_pkg::DATA_W-1:0] i_value,
    input  logic [1:0]                   i_operation,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [ssm_pkg::DATA_W-1:0] o_result_value,
    output logic                         o_is_last,
    output logic                         o_is_empty
);
    import ssm_pkg::*;

    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);

    t_state r_state, n_state;

    logic [CW-1:0]     r_cnt_a, n_cnt_a, r_cnt_b, n_cnt_b;
    logic [CW-1:0]     r_i, n_i, r_j, n_j;
    logic [1:0]        r_op, n_op;
    logic              r_pend_valid, n_pend_valid;
    logic [DATA_W-1:0] r_pend_value, n_pend_value;
    logic              r_out_valid, n_out_valid;
    logic [DATA_W-1:0] r_out_value, n_out_value;
    logic              r_out_last, n_out_last;
    logic              r_out_empty, n_out_empty;

    logic              in_acc, out_free;
    logic              we_a, we_b;
    logic [DATA_W-1:0] a_rdata, b_rdata;
    logic              a_more, b_more, both, lt, gt;
    logic              emit_req, adv_i, adv_j, done, step_go;
    logic [DATA_W-1:0] emit_val;

    assign in_acc   = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;
    assign we_a     = in_acc && (i_mode == MODE_LOAD_A) && (r_cnt_a < DEPTH_C);
    assign we_b     = in_acc && (i_mode == MODE_LOAD_B) && (r_cnt_b < DEPTH_C);

    // read address follows the next pointer so data lines up with r_i / r_j
    ssm_ram #(.WIDTH(DATA_W), .DEPTH(LIST_DEPTH)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (r_cnt_a[AW-1:0]),
        .i_wdata (i_value),
        .i_raddr (n_i[AW-1:0]),
        .o_rdata (a_rdata)
    );

    ssm_ram #(.WIDTH(DATA_W), .DEPTH(LIST_DEPTH)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (r_cnt_b[AW-1:0]),
        .i_wdata (i_value),
        .i_raddr (n_j[AW-1:0]),
        .o_rdata (b_rdata)
    );

    // merge step decision
    always_comb begin
        a_more   = r_i < r_cnt_a;
        b_more   = r_j < r_cnt_b;
        both     = a_more && b_more;
        lt       = $signed(a_rdata) < $signed(b_rdata);
        gt       = $signed(b_rdata) < $signed(a_rdata);
        emit_req = 1'b0;
        emit_val = a_rdata;
        adv_i    = 1'b0;
        adv_j    = 1'b0;
        priority if (both) begin
            priority if (lt) begin
                emit_req = (r_op != OP_INTERSECT);
                adv_i    = 1'b1;
            end else if (gt) begin
                emit_req = (r_op == OP_UNION);
                emit_val = b_rdata;
                adv_j    = 1'b1;
            end else begin
                emit_req = (r_op != OP_DIFF);
                adv_i    = 1'b1;
                adv_j    = 1'b1;
            end
        end else if (a_more) begin
            emit_req = 1'b1;
            adv_i    = 1'b1;
        end else begin
            emit_req = 1'b1;
            emit_val = b_rdata;
            adv_j    = 1'b1;
        end
        // tails that the operation does not copy end the walk
        done = (!a_more && !b_more)
            || (!both && (r_op == OP_INTERSECT))
            || (!a_more && (r_op == OP_DIFF));
        step_go = !emit_req || !r_pend_valid || out_free;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && (i_mode == MODE_RUN)) begin
                    n_state = (i_operation == OP_UNION || i_operation == OP_INTERSECT
                        || i_operation == OP_DIFF) ? ST_MERGE : ST_FINISH;
                end
            end
            ST_MERGE: begin
                if (done) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs and datapath next values
    always_comb begin
        o_stall      = (r_state != ST_IDLE);
        n_cnt_a      = r_cnt_a;
        n_cnt_b      = r_cnt_b;
        n_i          = r_i;
        n_j          = r_j;
        n_op         = r_op;
        n_pend_valid = r_pend_valid;
        n_pend_value = r_pend_value;
        n_out_valid  = r_out_valid && i_stall;
        n_out_value  = r_out_value;
        n_out_last   = r_out_last;
        n_out_empty  = r_out_empty;
        unique case (r_state)
            ST_IDLE: begin
                n_i = '0;
                n_j = '0;
                if (we_a) begin
                    n_cnt_a = r_cnt_a + CW'(1);
                end
                if (we_b) begin
                    n_cnt_b = r_cnt_b + CW'(1);
                end
                if (in_acc && (i_mode == MODE_RUN)) begin
                    n_op = i_operation;
                end
            end
            ST_MERGE: begin
                if (!done && step_go) begin
                    n_i = r_i + CW'(adv_i);
                    n_j = r_j + CW'(adv_j);
                    if (emit_req) begin
                        if (r_pend_valid) begin
                            n_out_valid = 1'b1;
                            n_out_value = r_pend_value;
                            n_out_last  = 1'b0;
                            n_out_empty = 1'b0;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_value = emit_val;
                    end
                end
            end
            ST_FINISH: begin
                n_i = '0;
                n_j = '0;
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = r_pend_valid ? r_pend_value : '0;
                    n_out_last   = 1'b1;
                    n_out_empty  = !r_pend_valid;
                    n_pend_valid = 1'b0;
                    n_cnt_a      = '0;
                    n_cnt_b      = '0;
                end
            end
            default: begin
                n_i = '0;
                n_j = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_cnt_a      <= '0;
            r_cnt_b      <= '0;
            r_i          <= '0;
            r_j          <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cnt_a      <= n_cnt_a;
            r_cnt_b      <= n_cnt_b;
            r_i          <= n_i;
            r_j          <= n_j;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
        r_op        <= n_op;
        r_pend_value <= n_pend_value;
        r_out_value <= n_out_value;
        r_out_last  <= n_out_last;
        r_out_empty <= n_out_empty;
    end

    assign o_valid        = r_out_valid;
    assign o_result_value = r_out_value;
    assign o_is_last      = r_out_last;
    assign o_is_empty     = r_out_empty;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt_a <= DEPTH_C) && (r_cnt_b <= DEPTH_C))
        else $error("list count beyond depth");

    a_ptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MERGE) |-> (r_i <= r_cnt_a) && (r_j <= r_cnt_b))
        else $error("merge pointer beyond list count");

    a_clear_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINISH && out_free) |=>
            (r_cnt_a == '0) && (r_cnt_b == '0) && (r_state == ST_IDLE))
        else $error("counts not cleared after run");

    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_pend_valid)
        else $error("held result word left over in idle");

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_empty) |-> (o_is_last && (o_result_value == '0)))
        else $error("empty word not marked last or not zero");
`endif

endmodule
